// File: sv/source_lexer_token_classifier_unit_defines.svh
// Assertion macros shared by the lexer checker.
// No dependencies; included by bare file name.
`ifndef SOURCE_LEXER_TOKEN_CLASSIFIER_UNIT_DEFINES_SVH
`define SOURCE_LEXER_TOKEN_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define STC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define STC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication, checked during reset too
`define STC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/stc_pkg.sv
// Shared constants, types and byte-class functions for the source lexer.
// No dependencies; used by every RTL file except the request interface.
`timescale 1ns / 1ps

package stc_pkg;

   localparam int KIND_BITS = 6;
   localparam int MODE_BITS = 4;

   // Lexer modes; codes above M_HEX decode as start
   localparam logic [MODE_BITS-1:0] M_START = 4'd0;
   localparam logic [MODE_BITS-1:0] M_LT    = 4'd1;
   localparam logic [MODE_BITS-1:0] M_GT    = 4'd2;
   localparam logic [MODE_BITS-1:0] M_EQ    = 4'd3;
   localparam logic [MODE_BITS-1:0] M_NOT   = 4'd4;
   localparam logic [MODE_BITS-1:0] M_AND   = 4'd5;
   localparam logic [MODE_BITS-1:0] M_OR    = 4'd6;
   localparam logic [MODE_BITS-1:0] M_MINUS = 4'd7;
   localparam logic [MODE_BITS-1:0] M_INT   = 4'd8;
   localparam logic [MODE_BITS-1:0] M_IDENT = 4'd9;
   localparam logic [MODE_BITS-1:0] M_STR   = 4'd10;
   localparam logic [MODE_BITS-1:0] M_HEX   = 4'd11;

   // Token kinds
   localparam logic [KIND_BITS-1:0] K_EOF    = 6'd0;
   localparam logic [KIND_BITS-1:0] K_WS     = 6'd1;
   localparam logic [KIND_BITS-1:0] K_NL     = 6'd2;
   localparam logic [KIND_BITS-1:0] K_LPAR   = 6'd3;
   localparam logic [KIND_BITS-1:0] K_RPAR   = 6'd4;
   localparam logic [KIND_BITS-1:0] K_LBRK   = 6'd5;
   localparam logic [KIND_BITS-1:0] K_RBRK   = 6'd6;
   localparam logic [KIND_BITS-1:0] K_LBRC   = 6'd7;
   localparam logic [KIND_BITS-1:0] K_RBRC   = 6'd8;
   localparam logic [KIND_BITS-1:0] K_SEMI   = 6'd9;
   localparam logic [KIND_BITS-1:0] K_COMMA  = 6'd10;
   localparam logic [KIND_BITS-1:0] K_PLUS   = 6'd11;
   localparam logic [KIND_BITS-1:0] K_MINUS  = 6'd12;
   localparam logic [KIND_BITS-1:0] K_STAR   = 6'd13;
   localparam logic [KIND_BITS-1:0] K_SLASH  = 6'd14;
   localparam logic [KIND_BITS-1:0] K_PCT    = 6'd15;
   localparam logic [KIND_BITS-1:0] K_CARET  = 6'd16;
   localparam logic [KIND_BITS-1:0] K_LT     = 6'd17;
   localparam logic [KIND_BITS-1:0] K_LE     = 6'd18;
   localparam logic [KIND_BITS-1:0] K_GT     = 6'd19;
   localparam logic [KIND_BITS-1:0] K_GE     = 6'd20;
   localparam logic [KIND_BITS-1:0] K_ASSIGN = 6'd21;
   localparam logic [KIND_BITS-1:0] K_EQEQ   = 6'd22;
   localparam logic [KIND_BITS-1:0] K_BANG   = 6'd23;
   localparam logic [KIND_BITS-1:0] K_NE     = 6'd24;
   localparam logic [KIND_BITS-1:0] K_ANDAND = 6'd25;
   localparam logic [KIND_BITS-1:0] K_OROR   = 6'd26;
   localparam logic [KIND_BITS-1:0] K_INT    = 6'd27;
   localparam logic [KIND_BITS-1:0] K_IDENT  = 6'd28;
   localparam logic [KIND_BITS-1:0] K_DSTR   = 6'd29;
   localparam logic [KIND_BITS-1:0] K_SSTR   = 6'd30;
   localparam logic [KIND_BITS-1:0] K_ERR    = 6'd31;
   localparam logic [KIND_BITS-1:0] K_UNTERM = 6'd32;

   // Source bytes with special meaning
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_AMP    = 8'h26;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_BAR    = 8'h7C;

   // Token write enables from the lexer core to the token queue
   typedef struct packed {
      logic tok0_en;
      logic tok1_en;
   } stc_push_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_ident_start(input logic [7:0] c);
      return is_alpha(c) || (c == CH_UNDER);
   endfunction

   function automatic logic is_ident_rest(input logic [7:0] c);
      return is_ident_start(c) || is_digit(c);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) ||
             ((c >= 8'h41) && (c <= 8'h46));
   endfunction

   // Second byte that completes a pending operator
   function automatic logic [7:0] pend_second(input logic [MODE_BITS-1:0] m);
      logic [7:0] r;
      case (m)
         M_AND:   r = CH_AMP;
         M_OR:    r = CH_BAR;
         default: r = CH_EQ;
      endcase
      return r;
   endfunction

   // Kind of a completed two-byte operator
   function automatic logic [KIND_BITS-1:0] pend_two(input logic [MODE_BITS-1:0] m);
      logic [KIND_BITS-1:0] r;
      case (m)
         M_LT:    r = K_LE;
         M_GT:    r = K_GE;
         M_EQ:    r = K_EQEQ;
         M_NOT:   r = K_NE;
         M_AND:   r = K_ANDAND;
         M_OR:    r = K_OROR;
         default: r = K_ERR;
      endcase
      return r;
   endfunction

   // Kind of a pending operator that stands alone
   function automatic logic [KIND_BITS-1:0] pend_one(input logic [MODE_BITS-1:0] m);
      logic [KIND_BITS-1:0] r;
      case (m)
         M_LT:    r = K_LT;
         M_GT:    r = K_GT;
         M_EQ:    r = K_ASSIGN;
         M_NOT:   r = K_BANG;
         default: r = K_ERR;
      endcase
      return r;
   endfunction

   // Single-byte punctuation; anything else is an error byte
   function automatic logic [KIND_BITS-1:0] single_kind(input logic [7:0] c);
      logic [KIND_BITS-1:0] r;
      case (c)
         8'h28:   r = K_LPAR;
         8'h29:   r = K_RPAR;
         8'h5B:   r = K_LBRK;
         8'h5D:   r = K_RBRK;
         8'h7B:   r = K_LBRC;
         8'h7D:   r = K_RBRC;
         8'h3B:   r = K_SEMI;
         8'h2C:   r = K_COMMA;
         8'h2B:   r = K_PLUS;
         8'h2A:   r = K_STAR;
         8'h2F:   r = K_SLASH;
         8'h25:   r = K_PCT;
         8'h5E:   r = K_CARET;
         default: r = K_ERR;
      endcase
      return r;
   endfunction

endpackage

// File: sv/stc_req_if.sv
// Request channel of the source lexer: one source byte or end marker.
// No dependencies.
`timescale 1ns / 1ps

interface stc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_of_text;

   modport source (output valid, output ch, output end_of_text, input ready);
   modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

// File: sv/stc_rsp_if.sv
// Response channel of the source lexer: one token per transfer.
// Depends on stc_pkg for the kind width.
`timescale 1ns / 1ps

interface stc_rsp_if #(
   parameter int POS_BITS = 16,
   parameter int LEN_BITS = 12
);
   logic                          valid;
   logic                          ready;
   logic [stc_pkg::KIND_BITS-1:0] token_kind;
   logic [POS_BITS-1:0]           token_line;
   logic [POS_BITS-1:0]           token_column;
   logic [LEN_BITS-1:0]           token_length;
   logic                          last_of_run;

   modport source (output valid, output token_kind, output token_line,
                   output token_column, output token_length, output last_of_run,
                   input ready);
   modport sink   (input valid, input token_kind, input token_line,
                   input token_column, input token_length, input last_of_run,
                   output ready);
endinterface

// File: sv/stc_token_fifo.sv
// Four-entry token queue between the lexer core and the response port.
// Takes up to two tokens a cycle, gives one while the reader is ready. Depends on stc_pkg.
`timescale 1ns / 1ps

module stc_token_fifo #(
   parameter int WIDTH = 51
) (
   input  logic                  clock,
   input  logic                  reset,
   input  stc_pkg::stc_push_type push,
   input  logic [WIDTH-1:0]      tok0,
   input  logic [WIDTH-1:0]      tok1,
   output logic                  room,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [WIDTH-1:0]      out_data
);
   import stc_pkg::*;

   localparam int DEPTH    = 4;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = PTR_BITS + 1;

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] head_ff, head_in;
   logic [PTR_BITS-1:0] tail_ff, tail_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [PTR_BITS-1:0] tail_next;
   logic [CNT_BITS-1:0] n_push;
   logic                pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[head_ff];
   // room for a worst-case pair of tokens
   assign room      = (count_ff <= CNT_BITS'(DEPTH - 2));
   assign tail_next = tail_ff + PTR_BITS'(1);
   assign n_push    = CNT_BITS'(push.tok0_en) + CNT_BITS'(push.tok1_en);

   // advance pointers and occupancy
   always_comb begin
      head_in  = pop ? head_ff + PTR_BITS'(1) : head_ff;
      tail_in  = tail_ff + PTR_BITS'(n_push);
      count_in = count_ff + n_push - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // store tokens in arrival order
   always_ff @(posedge clock) begin
      if (push.tok0_en) begin
         entry_ff[tail_ff] <= tok0;
      end
      if (push.tok1_en) begin
         entry_ff[tail_next] <= tok1;
      end
   end

endmodule

// File: sv/stc_lexer.sv
// Lexer core: state registers and the single-pass token decision.
// A byte that no pending token takes is lexed from start. Depends on stc_pkg.
`timescale 1ns / 1ps

module stc_lexer #(
   parameter int POS_BITS = 16,
   parameter int LEN_BITS = 12,
   parameter int TOK_BITS = stc_pkg::KIND_BITS + 2 * POS_BITS + LEN_BITS + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_fire,
   input  logic [7:0]            item_ch,
   input  logic                  item_eot,
   output stc_pkg::stc_push_type push,
   output logic [TOK_BITS-1:0]   tok0,
   output logic [TOK_BITS-1:0]   tok1
);
   import stc_pkg::*;

   localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
   localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);
   localparam logic [LEN_BITS-1:0] LEN_TWO = LEN_BITS'(2);
   localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

   logic [MODE_BITS-1:0] mode_ff, mode_in;
   logic                 esc_ff, esc_in;
   logic [1:0]           hex_ff, hex_in;
   logic                 dbl_ff, dbl_in;
   logic [POS_BITS-1:0]  line_ff, line_in;
   logic [POS_BITS-1:0]  col_ff, col_in;
   logic [POS_BITS-1:0]  scol_ff, scol_in;
   logic [LEN_BITS-1:0]  len_ff, len_in;

   logic [MODE_BITS-1:0] mode_eff;
   logic [LEN_BITS-1:0]  len_p1;
   logic [1:0]           hex_p1;
   logic [7:0]           quote;
   logic                 str_path;
   logic                 go_start;
   logic                 a_emit, b_emit;
   logic [KIND_BITS-1:0] a_kind, b_kind;
   logic [LEN_BITS-1:0]  a_len, b_len;
   logic [TOK_BITS-1:0]  tok_a, tok_b;

   assign mode_eff = (mode_ff > M_HEX) ? M_START : mode_ff;
   assign len_p1   = (len_ff == LEN_MAX) ? len_ff : len_ff + LEN_ONE;
   assign hex_p1   = hex_ff + 2'd1;
   assign quote    = dbl_ff ? CH_DQUOTE : CH_SQUOTE;

   // decide tokens and next lexer state for the held byte
   always_comb begin
      mode_in  = mode_ff;
      esc_in   = esc_ff;
      hex_in   = hex_ff;
      dbl_in   = dbl_ff;
      scol_in  = scol_ff;
      len_in   = len_ff;
      str_path = 1'b0;
      go_start = 1'b0;
      a_emit   = 1'b0;
      a_kind   = K_ERR;
      a_len    = LEN_ONE;
      b_emit   = 1'b0;
      b_kind   = K_ERR;
      b_len    = LEN_ONE;

      // finish or extend the pending token
      case (mode_eff)
         M_LT, M_GT, M_EQ, M_NOT, M_AND, M_OR: begin
            a_emit = 1'b1;
            if (!item_eot && (item_ch == pend_second(mode_eff))) begin
               a_kind  = pend_two(mode_eff);
               a_len   = LEN_TWO;
               mode_in = M_START;
            end else begin
               a_kind   = pend_one(mode_eff);
               go_start = 1'b1;
            end
         end
         M_MINUS: begin
            if (!item_eot && is_digit(item_ch)) begin
               mode_in = M_INT;
               len_in  = len_p1;
            end else begin
               a_emit   = 1'b1;
               a_kind   = K_MINUS;
               go_start = 1'b1;
            end
         end
         M_INT, M_IDENT: begin
            if (!item_eot && ((mode_eff == M_INT) ? is_digit(item_ch)
                                                  : is_ident_rest(item_ch))) begin
               len_in = len_p1;
            end else begin
               a_emit   = 1'b1;
               a_kind   = (mode_eff == M_INT) ? K_INT : K_IDENT;
               a_len    = len_ff;
               go_start = 1'b1;
            end
         end
         M_STR: begin
            str_path = 1'b1;
         end
         M_HEX: begin
            if (!item_eot && is_hex(item_ch)) begin
               len_in = len_p1;
               hex_in = hex_p1;
               if (hex_p1 >= 2'd2) begin
                  mode_in = M_STR;
               end
            end else begin
               // cut-short escape: the byte is lexed as part of the string
               str_path = 1'b1;
            end
         end
         default: begin
            go_start = 1'b1;
         end
      endcase

      // string body, closing quote and unterminated string
      if (str_path) begin
         mode_in = M_STR;
         if (item_eot || ((item_ch == CH_NL) && !esc_ff)) begin
            a_emit   = 1'b1;
            a_kind   = K_UNTERM;
            a_len    = len_ff;
            esc_in   = 1'b0;
            go_start = 1'b1;
         end else begin
            len_in = len_p1;
            if (esc_ff) begin
               if (item_ch == CH_X) begin
                  mode_in = M_HEX;
                  hex_in  = 2'd0;
               end
               esc_in = 1'b0;
            end else if (item_ch == CH_BSLASH) begin
               esc_in = 1'b1;
            end else if (item_ch == quote) begin
               a_emit  = 1'b1;
               a_kind  = dbl_ff ? K_DSTR : K_SSTR;
               a_len   = len_p1;
               mode_in = M_START;
            end
         end
      end

      // lex the byte from start
      if (go_start) begin
         mode_in = M_START;
         scol_in = col_ff;
         len_in  = '0;
         if (item_eot) begin
            b_emit = 1'b1;
            b_kind = K_EOF;
            b_len  = '0;
         end else if ((item_ch == CH_SPACE) || (item_ch == CH_TAB)) begin
            b_emit = 1'b1;
            b_kind = K_WS;
         end else if (item_ch == CH_NL) begin
            b_emit = 1'b1;
            b_kind = K_NL;
         end else if (item_ch == CH_LT) begin
            mode_in = M_LT;
         end else if (item_ch == CH_GT) begin
            mode_in = M_GT;
         end else if (item_ch == CH_EQ) begin
            mode_in = M_EQ;
         end else if (item_ch == CH_BANG) begin
            mode_in = M_NOT;
         end else if (item_ch == CH_AMP) begin
            mode_in = M_AND;
         end else if (item_ch == CH_BAR) begin
            mode_in = M_OR;
         end else if (item_ch == CH_MINUS) begin
            mode_in = M_MINUS;
            len_in  = LEN_ONE;
         end else if ((item_ch == CH_DQUOTE) || (item_ch == CH_SQUOTE)) begin
            mode_in = M_STR;
            dbl_in  = (item_ch == CH_DQUOTE);
            esc_in  = 1'b0;
            len_in  = LEN_ONE;
         end else if (is_digit(item_ch)) begin
            mode_in = M_INT;
            len_in  = LEN_ONE;
         end else if (is_ident_start(item_ch)) begin
            mode_in = M_IDENT;
            len_in  = LEN_ONE;
         end else begin
            b_emit = 1'b1;
            b_kind = single_kind(item_ch);
         end
      end
   end

   // advance position once per byte, saturating
   always_comb begin
      line_in = line_ff;
      col_in  = col_ff;
      if (item_ch == CH_NL) begin
         line_in = (line_ff == POS_MAX) ? line_ff : line_ff + POS_ONE;
         col_in  = POS_ONE;
      end else begin
         col_in = (col_ff == POS_MAX) ? col_ff : col_ff + POS_ONE;
      end
   end

   // pack tokens; the pending token carries the held start column
   assign tok_a = {a_kind, line_ff, scol_ff, a_len, !b_emit};
   assign tok_b = {b_kind, line_ff, col_ff, b_len, 1'b1};

   always_comb begin
      push.tok0_en = item_fire && (a_emit || b_emit);
      push.tok1_en = item_fire && a_emit && b_emit;
      tok0         = a_emit ? tok_a : tok_b;
      tok1         = tok_b;
   end

   // state update; end of text always ends in eof and a fresh start
   always_ff @(posedge clock) begin
      if (reset || (item_fire && item_eot)) begin
         mode_ff <= M_START;
         esc_ff  <= 1'b0;
         hex_ff  <= 2'd0;
         dbl_ff  <= 1'b0;
         line_ff <= POS_ONE;
         col_ff  <= POS_ONE;
         scol_ff <= POS_ONE;
         len_ff  <= '0;
      end else if (item_fire) begin
         mode_ff <= mode_in;
         esc_ff  <= esc_in;
         hex_ff  <= hex_in;
         dbl_ff  <= dbl_in;
         line_ff <= line_in;
         col_ff  <= col_in;
         scol_ff <= scol_in;
         len_ff  <= len_in;
      end
   end

endmodule

// File: sv/source_lexer_token_classifier_unit.sv
// Source lexer top level. A taken request waits in the input register until the
// token queue has room for two tokens; its tokens then go into the queue, whose
// head drives the response port. Throughput: one request per cycle while the queue
// has room; a request that completes two tokens yields two response transfers.
// Reset (synchronous, active high) returns the lexer to start, line and column 1,
// and empties the input register and the token queue.
`timescale 1ns / 1ps

module source_lexer_token_classifier_unit #(
   parameter int POS_BITS = 16,
   parameter int LEN_BITS = 12
) (
   input logic   clock,
   input logic   reset,
   stc_req_if.sink   req_bus,
   stc_rsp_if.source rsp_bus
);
   import stc_pkg::*;

   localparam int TOK_BITS = KIND_BITS + 2 * POS_BITS + LEN_BITS + 1;

   logic                hold_valid_ff, hold_valid_in;
   logic [7:0]          hold_ch_ff, hold_ch_in;
   logic                hold_eot_ff, hold_eot_in;
   logic                fire;
   logic                room;
   stc_push_type        push;
   logic [TOK_BITS-1:0] tok0, tok1, head_tok;

   // process the held request when the queue can take two tokens
   assign fire          = hold_valid_ff && room;
   assign req_bus.ready = !hold_valid_ff || fire;

   // capture a request, drop the held one once processed
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_ch_in    = hold_ch_ff;
      hold_eot_in   = hold_eot_ff;
      if (req_bus.ready) begin
         hold_valid_in = req_bus.valid;
         hold_ch_in    = req_bus.ch;
         hold_eot_in   = req_bus.end_of_text;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ch_ff  <= hold_ch_in;
      hold_eot_ff <= hold_eot_in;
   end

   stc_lexer #(
      .POS_BITS (POS_BITS),
      .LEN_BITS (LEN_BITS),
      .TOK_BITS (TOK_BITS)
   ) u_lexer (
      .clock     (clock),
      .reset     (reset),
      .item_fire (fire),
      .item_ch   (hold_ch_ff),
      .item_eot  (hold_eot_ff),
      .push      (push),
      .tok0      (tok0),
      .tok1      (tok1)
   );

   stc_token_fifo #(
      .WIDTH (TOK_BITS)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .tok0      (tok0),
      .tok1      (tok1),
      .room      (room),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (head_tok)
   );

   // unpack the head token onto the response port
   assign rsp_bus.token_kind   = head_tok[TOK_BITS-1 -: KIND_BITS];
   assign rsp_bus.token_line   = head_tok[2*POS_BITS+LEN_BITS -: POS_BITS];
   assign rsp_bus.token_column = head_tok[POS_BITS+LEN_BITS -: POS_BITS];
   assign rsp_bus.token_length = head_tok[LEN_BITS -: LEN_BITS];
   assign rsp_bus.last_of_run  = head_tok[0];

endmodule

// File: sv/stc_checker.sv
// Port-level checks for the source lexer, bound to the top level.
// Depends on stc_pkg and source_lexer_token_classifier_unit_defines.svh.
`timescale 1ns / 1ps
`include "source_lexer_token_classifier_unit_defines.svh"

module stc_checker #(
   parameter int POS_BITS = 16,
   parameter int LEN_BITS = 12
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [stc_pkg::KIND_BITS-1:0] rsp_kind,
   input logic [POS_BITS-1:0]           rsp_line,
   input logic [POS_BITS-1:0]           rsp_column,
   input logic [LEN_BITS-1:0]           rsp_length,
   input logic                          rsp_last
);
   import stc_pkg::*;

   // a stalled token stays offered
   `STC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "token dropped while stalled")

   // reset empties the token queue
   `STC_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "token offered after reset")

   // eof is empty and always ends its run
   `STC_ASSERT_IMPLY(a_eof_shape, clock, reset, rsp_valid && (rsp_kind == K_EOF), (rsp_length == '0) && rsp_last, "malformed eof token")

   // positions never fall below one and kinds stay in range
   `STC_ASSERT_IMPLY(a_tok_range, clock, reset, rsp_valid, (rsp_line != '0) && (rsp_column != '0) && (rsp_kind <= K_UNTERM), "token field out of range")

endmodule

bind source_lexer_token_classifier_unit stc_checker #(
   .POS_BITS (POS_BITS),
   .LEN_BITS (LEN_BITS)
) u_stc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_kind   (rsp_bus.token_kind),
   .rsp_line   (rsp_bus.token_line),
   .rsp_column (rsp_bus.token_column),
   .rsp_length (rsp_bus.token_length),
   .rsp_last   (rsp_bus.last_of_run)
);
